// ----- hdl/scff_pkg.sv -----
// Shared types, widths and codes of the sigma-clipped feature flow block.
package scff_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int POS_W        = 18;
    localparam int DISP_W       = 19;
    localparam int DMAG_W       = 18;
    localparam int SUM_W        = 25;
    localparam int SMAG_W       = 24;
    localparam int SQ_W         = 36;
    localparam int QSUM_W       = 42;
    localparam int CQ_W         = 49;
    localparam int VM_W         = 65;
    localparam int BND_W        = 81;
    localparam int ERR_W        = 26;
    localparam int EMAG_W       = 25;
    localparam int ESQ_W        = 50;
    localparam int MULT_W       = 16;
    localparam int CFG_W        = 16;
    localparam int QUAL_W       = 8;
    localparam int DIV_N_W      = 24;
    localparam int DIV_D_W      = 8;
    localparam int DIV_S_W      = 5;
    localparam int FLOW_LIMIT   = 262143;

    // tracker status codes
    localparam logic [1:0] ST_LOST   = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_NEW    = 2'd2;

    // configuration register indexes
    localparam logic CFG_FEATURES_USED = 1'b0;
    localparam logic CFG_CONF_MULT     = 1'b1;

    // datapath operations
    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_TAKE = 5'd1;
    localparam logic [4:0] OP_DIFF = 5'd2;
    localparam logic [4:0] OP_SQ   = 5'd3;
    localparam logic [4:0] OP_ACC  = 5'd4;
    localparam logic [4:0] OP_VAR0 = 5'd5;
    localparam logic [4:0] OP_VAR1 = 5'd6;
    localparam logic [4:0] OP_VAR2 = 5'd7;
    localparam logic [4:0] OP_VAR3 = 5'd8;
    localparam logic [4:0] OP_PRD  = 5'd9;
    localparam logic [4:0] OP_PERR = 5'd10;
    localparam logic [4:0] OP_PSQ  = 5'd11;
    localparam logic [4:0] OP_PCMP = 5'd12;
    localparam logic [4:0] OP_DIVX = 5'd13;
    localparam logic [4:0] OP_DIVY = 5'd14;
    localparam logic [4:0] OP_DIVQ = 5'd15;
    localparam logic [4:0] OP_OUT  = 5'd16;

    // divider result destinations
    localparam logic [1:0] DSEL_X = 2'd0;
    localparam logic [1:0] DSEL_Y = 2'd1;
    localparam logic [1:0] DSEL_Q = 2'd2;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
        logic pass_done;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

// ----- hdl/sigma_clipped_feature_flow_top.sv -----
// Sigma-clipped mean feature flow: top level joining controller and datapath.
// Each feature transaction passes through accept, difference, square and accumulate steps;
// a surplus transaction beyond the slot count passes through accept and check only.
// A frame-closing transaction then runs the frame-end work and an output step before the result:
// four bound stages, a four-step clipping loop per delivered slot, three 24-step divisions.
// Input is not taken during that frame-end work; a waiting result does not block intake.
// rst_n is asynchronous, active low; slot position memories are not cleared by reset.
module sigma_clipped_feature_flow_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [scff_pkg::CFG_W-1:0]         cfg_wdata,
    // feature transactions
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [scff_pkg::POS_W-1:0]         pos_x,
    input  logic [scff_pkg::POS_W-1:0]         pos_y,
    input  logic [1:0]                         feature_status,
    input  logic                               frame_last,
    // result transactions
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [scff_pkg::DISP_W-1:0] flow_x,
    output logic signed [scff_pkg::DISP_W-1:0] flow_y,
    output logic [scff_pkg::QUAL_W-1:0]        quality,
    output logic [scff_pkg::MAX_FEATURES-1:0]  next_active_mask
);

    scff_pkg::cmd_t    cmd;
    scff_pkg::status_t sts;

    // sequencer: one state per datapath step
    scff_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, sums, keep test, shared divider, result register
    scff_dp u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .feature_status   (feature_status),
        .frame_last       (frame_last),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .flow_x           (flow_x),
        .flow_y           (flow_y),
        .quality          (quality),
        .next_active_mask (next_active_mask)
    );

endmodule

// ----- hdl/scff_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module scff_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [scff_pkg::DIV_N_W-1:0] num,
    input  logic [scff_pkg::DIV_D_W-1:0] den,
    output logic [scff_pkg::DIV_N_W-1:0] quo,
    output logic                         done
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [scff_pkg::DIV_S_W-1:0] step_reg;
    logic [scff_pkg::DIV_D_W-1:0] rem_reg;
    logic [scff_pkg::DIV_D_W-1:0] den_reg;
    logic [scff_pkg::DIV_N_W-1:0] quo_reg;
    logic [scff_pkg::DIV_D_W:0]   shifted;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[scff_pkg::DIV_N_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= scff_pkg::DIV_S_W'(scff_pkg::DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? scff_pkg::DIV_D_W'(shifted - {1'b0, den_reg})
                            : shifted[scff_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[scff_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- hdl/scff_dp.sv -----
// Datapath: slot memories, accumulators, clipping test, divider and result registers.
module scff_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [scff_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [scff_pkg::POS_W-1:0]          pos_x,
    input  logic [scff_pkg::POS_W-1:0]          pos_y,
    input  logic [1:0]                          feature_status,
    input  logic                                frame_last,
    input  scff_pkg::cmd_t                      cmd,
    output scff_pkg::status_t                   sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [scff_pkg::DISP_W-1:0]  flow_x,
    output logic signed [scff_pkg::DISP_W-1:0]  flow_y,
    output logic [scff_pkg::QUAL_W-1:0]         quality,
    output logic [scff_pkg::MAX_FEATURES-1:0]   next_active_mask
);

    localparam int PW = 2 * scff_pkg::POS_W;
    localparam int DW = 2 * scff_pkg::DISP_W + 2;

    function automatic logic [scff_pkg::DMAG_W-1:0] mag_d(
        input logic signed [scff_pkg::DISP_W-1:0] v);
        logic signed [scff_pkg::DISP_W-1:0] a;
        a = v[scff_pkg::DISP_W-1] ? -v : v;
        return a[scff_pkg::DMAG_W-1:0];
    endfunction

    function automatic logic [scff_pkg::SMAG_W-1:0] mag_s(
        input logic signed [scff_pkg::SUM_W-1:0] v);
        logic signed [scff_pkg::SUM_W-1:0] a;
        a = v[scff_pkg::SUM_W-1] ? -v : v;
        return a[scff_pkg::SMAG_W-1:0];
    endfunction

    function automatic logic [scff_pkg::EMAG_W-1:0] mag_e(
        input logic signed [scff_pkg::ERR_W-1:0] v);
        logic signed [scff_pkg::ERR_W-1:0] a;
        a = v[scff_pkg::ERR_W-1] ? -v : v;
        return a[scff_pkg::EMAG_W-1:0];
    endfunction

    // configuration
    logic [scff_pkg::CNT_W-1:0]  fu_reg;
    logic [scff_pkg::MULT_W-1:0] mult_reg;
    logic [scff_pkg::CNT_W-1:0]  n;

    // intake
    logic [scff_pkg::CNT_W-1:0]  cnt_reg;
    logic                        hp_reg;
    logic [scff_pkg::POS_W-1:0]  in_x_reg;
    logic [scff_pkg::POS_W-1:0]  in_y_reg;
    logic [1:0]                  in_st_reg;
    logic                        in_last_reg;
    logic [PW-1:0]               prev_mem [scff_pkg::MAX_FEATURES];
    logic [PW-1:0]               prev_rd_reg;
    logic [DW-1:0]               disp_mem [scff_pkg::MAX_FEATURES];
    logic [DW-1:0]               disp_rd_reg;
    logic signed [scff_pkg::DISP_W-1:0] dx_reg;
    logic signed [scff_pkg::DISP_W-1:0] dy_reg;
    logic                        act_reg;
    logic [scff_pkg::SQ_W-1:0]   sqx_reg;
    logic [scff_pkg::SQ_W-1:0]   sqy_reg;

    // frame sums
    logic [scff_pkg::CNT_W-1:0]         c_reg;
    logic signed [scff_pkg::SUM_W-1:0]  sx_reg;
    logic signed [scff_pkg::SUM_W-1:0]  sy_reg;
    logic [scff_pkg::QSUM_W-1:0]        qx_reg;
    logic [scff_pkg::QSUM_W-1:0]        qy_reg;

    // bound
    logic [scff_pkg::CQ_W-1:0]  cqx_reg;
    logic [scff_pkg::CQ_W-1:0]  cqy_reg;
    logic [scff_pkg::CQ_W-1:0]  s2x_reg;
    logic [scff_pkg::CQ_W-1:0]  s2y_reg;
    logic [scff_pkg::CQ_W-1:0]  vx_reg;
    logic [scff_pkg::CQ_W-1:0]  vy_reg;
    logic [scff_pkg::VM_W-1:0]  vmx_reg;
    logic [scff_pkg::VM_W-1:0]  vmy_reg;
    logic [scff_pkg::BND_W-1:0] bx_reg;
    logic [scff_pkg::BND_W-1:0] by_reg;

    // clipping pass
    logic [scff_pkg::IDX_W-1:0]         idx_reg;
    logic signed [scff_pkg::DISP_W-1:0] pd_x;
    logic signed [scff_pkg::DISP_W-1:0] pd_y;
    logic [1:0]                         pd_st;
    logic signed [scff_pkg::ERR_W+1-1:0] cdx;
    logic signed [scff_pkg::ERR_W+1-1:0] cdy;
    logic signed [scff_pkg::ERR_W-1:0]  ex_reg;
    logic signed [scff_pkg::ERR_W-1:0]  ey_reg;
    logic [scff_pkg::ESQ_W-1:0]         e2x_reg;
    logic [scff_pkg::ESQ_W-1:0]         e2y_reg;
    logic                               keep_x;
    logic                               keep_y;
    logic                               act_p;
    logic                               keep;
    logic [scff_pkg::CNT_W-1:0]         kept_reg;
    logic signed [scff_pkg::SUM_W-1:0]  kx_reg;
    logic signed [scff_pkg::SUM_W-1:0]  ky_reg;
    logic [scff_pkg::MAX_FEATURES-1:0]  mask_reg;

    // division and results
    logic                                div_start;
    logic [scff_pkg::DIV_N_W-1:0]        div_num;
    logic [scff_pkg::DIV_D_W-1:0]        div_den;
    logic                                div_neg;
    logic [scff_pkg::DIV_N_W-1:0]        div_quo;
    logic                                div_done;
    logic [1:0]                          sel_reg;
    logic                                neg_reg;
    logic [scff_pkg::DMAG_W-1:0]         q_clamp;
    logic signed [scff_pkg::DISP_W-1:0]  q_signed;
    logic [15:0]                         qual_num;
    logic signed [scff_pkg::SUM_W-1:0]   flow_sum;
    logic [scff_pkg::CNT_W-1:0]          flow_cnt;
    logic signed [scff_pkg::DISP_W-1:0]  fx_reg;
    logic signed [scff_pkg::DISP_W-1:0]  fy_reg;
    logic [scff_pkg::QUAL_W-1:0]         qual_reg;
    logic                                out_valid_reg;
    logic signed [scff_pkg::DISP_W-1:0]  out_fx_reg;
    logic signed [scff_pkg::DISP_W-1:0]  out_fy_reg;
    logic [scff_pkg::QUAL_W-1:0]         out_q_reg;
    logic [scff_pkg::MAX_FEATURES-1:0]   out_mask_reg;

    assign n = (fu_reg == '0) ? scff_pkg::CNT_W'(1)
             : (fu_reg > scff_pkg::CNT_W'(scff_pkg::MAX_FEATURES))
                 ? scff_pkg::CNT_W'(scff_pkg::MAX_FEATURES) : fu_reg;

    assign pd_x  = disp_rd_reg[DW-1 -: scff_pkg::DISP_W];
    assign pd_y  = disp_rd_reg[2 +: scff_pkg::DISP_W];
    assign pd_st = disp_rd_reg[1:0];

    assign cdx = $signed({1'b0, c_reg}) * pd_x;
    assign cdy = $signed({1'b0, c_reg}) * pd_y;

    assign keep_x = {15'b0, e2x_reg, 16'b0} < bx_reg;
    assign keep_y = {15'b0, e2y_reg, 16'b0} < by_reg;
    assign act_p  = hp_reg && (pd_st == scff_pkg::ST_ACTIVE);
    assign keep   = act_p && keep_x && keep_y;

    // divider operands: kept mean when anything survived, plain mean otherwise; quality is kept * 255 / n, rounded
    always_comb
    begin
        flow_sum  = '0;
        flow_cnt  = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = scff_pkg::DIV_D_W'(1);
        div_neg   = 1'b0;
        qual_num  = 16'(kept_reg) * 16'd510 + 16'(n);
        case (cmd.op)
            scff_pkg::OP_DIVX,
            scff_pkg::OP_DIVY:
            begin
                div_start = 1'b1;
                if (kept_reg != '0)
                begin
                    flow_sum = (cmd.op == scff_pkg::OP_DIVX) ? kx_reg : ky_reg;
                    flow_cnt = kept_reg;
                end
                else
                begin
                    flow_sum = (cmd.op == scff_pkg::OP_DIVX) ? sx_reg : sy_reg;
                    flow_cnt = c_reg;
                end
                if (flow_cnt != '0)
                begin
                    div_num = mag_s(flow_sum);
                    div_den = scff_pkg::DIV_D_W'(flow_cnt);
                    div_neg = flow_sum[scff_pkg::SUM_W-1];
                end
            end
            scff_pkg::OP_DIVQ:
            begin
                div_start = 1'b1;
                div_num   = scff_pkg::DIV_N_W'(qual_num);
                div_den   = {n, 1'b0};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign q_clamp  = (div_quo > scff_pkg::DIV_N_W'(scff_pkg::FLOW_LIMIT))
                    ? scff_pkg::DMAG_W'(scff_pkg::FLOW_LIMIT)
                    : div_quo[scff_pkg::DMAG_W-1:0];
    assign q_signed = neg_reg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

    scff_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fu_reg        <= scff_pkg::CNT_W'(64);
            mult_reg      <= scff_pkg::MULT_W'(421);
            cnt_reg       <= '0;
            hp_reg        <= 1'b0;
            c_reg         <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == scff_pkg::CFG_FEATURES_USED)
                begin
                    fu_reg <= cfg_wdata[scff_pkg::CNT_W-1:0];
                end
                else
                begin
                    mult_reg <= cfg_wdata;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                scff_pkg::OP_DIFF:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (hp_reg && in_st_reg == scff_pkg::ST_ACTIVE)
                    begin
                        c_reg  <= c_reg + 1'b1;
                        sx_reg <= sx_reg + scff_pkg::SUM_W'(
                                  $signed({1'b0, in_x_reg}) - $signed({1'b0, prev_rd_reg[PW-1 -: scff_pkg::POS_W]}));
                        sy_reg <= sy_reg + scff_pkg::SUM_W'(
                                  $signed({1'b0, in_y_reg}) - $signed({1'b0, prev_rd_reg[scff_pkg::POS_W-1:0]}));
                    end
                end
                scff_pkg::OP_ACC:
                begin
                    qx_reg <= qx_reg + scff_pkg::QSUM_W'(sqx_reg);
                    qy_reg <= qy_reg + scff_pkg::QSUM_W'(sqy_reg);
                end
                scff_pkg::OP_VAR3:
                begin
                    idx_reg  <= '0;
                    kept_reg <= '0;
                    kx_reg   <= '0;
                    ky_reg   <= '0;
                    mask_reg <= '0;
                end
                scff_pkg::OP_PCMP:
                begin
                    if (keep)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                        kx_reg   <= kx_reg + scff_pkg::SUM_W'(pd_x);
                        ky_reg   <= ky_reg + scff_pkg::SUM_W'(pd_y);
                    end
                    mask_reg[idx_reg] <= (pd_st == scff_pkg::ST_NEW)
                        || ((pd_st == scff_pkg::ST_ACTIVE) && (!hp_reg || keep));
                    idx_reg <= idx_reg + 1'b1;
                end
                scff_pkg::OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    hp_reg        <= 1'b1;
                    cnt_reg       <= '0;
                    c_reg         <= '0;
                    sx_reg        <= '0;
                    sy_reg        <= '0;
                    qx_reg        <= '0;
                    qy_reg        <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (sel_reg)
                scff_pkg::DSEL_X: fx_reg   <= q_signed;
                scff_pkg::DSEL_Y: fy_reg   <= q_signed;
                default:          qual_reg <= div_quo[scff_pkg::QUAL_W-1:0];
            endcase
        end
        case (cmd.op)
            scff_pkg::OP_TAKE:
            begin
                in_x_reg    <= pos_x;
                in_y_reg    <= pos_y;
                in_st_reg   <= (feature_status == 2'd3) ? scff_pkg::ST_LOST : feature_status;
                in_last_reg <= frame_last;
                prev_rd_reg <= prev_mem[cnt_reg[scff_pkg::IDX_W-1:0]];
            end
            scff_pkg::OP_DIFF:
            begin
                dx_reg  <= $signed({1'b0, in_x_reg})
                         - $signed({1'b0, prev_rd_reg[PW-1 -: scff_pkg::POS_W]});
                dy_reg  <= $signed({1'b0, in_y_reg})
                         - $signed({1'b0, prev_rd_reg[scff_pkg::POS_W-1:0]});
                act_reg <= hp_reg && (in_st_reg == scff_pkg::ST_ACTIVE);
                prev_mem[cnt_reg[scff_pkg::IDX_W-1:0]] <= {in_x_reg, in_y_reg};
                disp_mem[cnt_reg[scff_pkg::IDX_W-1:0]] <= {
                    $signed({1'b0, in_x_reg}) - $signed({1'b0, prev_rd_reg[PW-1 -: scff_pkg::POS_W]}),
                    $signed({1'b0, in_y_reg}) - $signed({1'b0, prev_rd_reg[scff_pkg::POS_W-1:0]}),
                    in_st_reg};
            end
            scff_pkg::OP_SQ:
            begin
                sqx_reg <= act_reg ? mag_d(dx_reg) * mag_d(dx_reg) : '0;
                sqy_reg <= act_reg ? mag_d(dy_reg) * mag_d(dy_reg) : '0;
            end
            scff_pkg::OP_VAR0:
            begin
                cqx_reg <= c_reg * qx_reg;
                cqy_reg <= c_reg * qy_reg;
                s2x_reg <= scff_pkg::CQ_W'(mag_s(sx_reg) * mag_s(sx_reg));
                s2y_reg <= scff_pkg::CQ_W'(mag_s(sy_reg) * mag_s(sy_reg));
            end
            scff_pkg::OP_VAR1:
            begin
                vx_reg <= cqx_reg - s2x_reg;
                vy_reg <= cqy_reg - s2y_reg;
            end
            scff_pkg::OP_VAR2:
            begin
                vmx_reg <= vx_reg * mult_reg;
                vmy_reg <= vy_reg * mult_reg;
            end
            scff_pkg::OP_VAR3:
            begin
                bx_reg <= vmx_reg * mult_reg;
                by_reg <= vmy_reg * mult_reg;
            end
            scff_pkg::OP_PRD:
            begin
                disp_rd_reg <= disp_mem[idx_reg];
            end
            scff_pkg::OP_PERR:
            begin
                ex_reg <= scff_pkg::ERR_W'(cdx - (scff_pkg::ERR_W+1)'(sx_reg));
                ey_reg <= scff_pkg::ERR_W'(cdy - (scff_pkg::ERR_W+1)'(sy_reg));
            end
            scff_pkg::OP_PSQ:
            begin
                e2x_reg <= mag_e(ex_reg) * mag_e(ex_reg);
                e2y_reg <= mag_e(ey_reg) * mag_e(ey_reg);
            end
            scff_pkg::OP_DIVX:
            begin
                sel_reg <= scff_pkg::DSEL_X;
                neg_reg <= div_neg;
            end
            scff_pkg::OP_DIVY:
            begin
                sel_reg <= scff_pkg::DSEL_Y;
                neg_reg <= div_neg;
            end
            scff_pkg::OP_DIVQ:
            begin
                sel_reg <= scff_pkg::DSEL_Q;
                neg_reg <= 1'b0;
            end
            scff_pkg::OP_OUT:
            begin
                out_fx_reg   <= fx_reg;
                out_fy_reg   <= fy_reg;
                out_q_reg    <= qual_reg;
                out_mask_reg <= mask_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.skip      = cnt_reg >= n;
    assign sts.last      = in_last_reg;
    assign sts.pass_done = {1'b0, idx_reg} == (cnt_reg - 1'b1);
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid        = out_valid_reg;
    assign flow_x           = out_fx_reg;
    assign flow_y           = out_fy_reg;
    assign quality          = out_q_reg;
    assign next_active_mask = out_mask_reg;

endmodule

// ----- hdl/scff_ctrl.sv -----
// Controller: sequences intake, bound computation, clipping pass and divisions.
module scff_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scff_pkg::status_t sts,
    output scff_pkg::cmd_t    cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_SQ   = 5'd2;
    localparam logic [4:0] S_ACC  = 5'd3;
    localparam logic [4:0] S_V0   = 5'd4;
    localparam logic [4:0] S_V1   = 5'd5;
    localparam logic [4:0] S_V2   = 5'd6;
    localparam logic [4:0] S_V3   = 5'd7;
    localparam logic [4:0] S_PRD  = 5'd8;
    localparam logic [4:0] S_PERR = 5'd9;
    localparam logic [4:0] S_PSQ  = 5'd10;
    localparam logic [4:0] S_PCMP = 5'd11;
    localparam logic [4:0] S_DX   = 5'd12;
    localparam logic [4:0] S_WX   = 5'd13;
    localparam logic [4:0] S_DY   = 5'd14;
    localparam logic [4:0] S_WY   = 5'd15;
    localparam logic [4:0] S_DQ   = 5'd16;
    localparam logic [4:0] S_WQ   = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = scff_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = scff_pkg::OP_TAKE;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.skip)
                begin
                    state_next = sts.last ? S_V0 : S_IDLE;
                end
                else
                begin
                    cmd.op     = scff_pkg::OP_DIFF;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op     = scff_pkg::OP_SQ;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = scff_pkg::OP_ACC;
                state_next = sts.last ? S_V0 : S_IDLE;
            end
            S_V0:
            begin
                cmd.op     = scff_pkg::OP_VAR0;
                state_next = S_V1;
            end
            S_V1:
            begin
                cmd.op     = scff_pkg::OP_VAR1;
                state_next = S_V2;
            end
            S_V2:
            begin
                cmd.op     = scff_pkg::OP_VAR2;
                state_next = S_V3;
            end
            S_V3:
            begin
                cmd.op     = scff_pkg::OP_VAR3;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.op     = scff_pkg::OP_PRD;
                state_next = S_PERR;
            end
            S_PERR:
            begin
                cmd.op     = scff_pkg::OP_PERR;
                state_next = S_PSQ;
            end
            S_PSQ:
            begin
                cmd.op     = scff_pkg::OP_PSQ;
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                cmd.op     = scff_pkg::OP_PCMP;
                state_next = sts.pass_done ? S_DX : S_PRD;
            end
            S_DX:
            begin
                cmd.op     = scff_pkg::OP_DIVX;
                state_next = S_WX;
            end
            S_WX:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                cmd.op     = scff_pkg::OP_DIVY;
                state_next = S_WY;
            end
            S_WY:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DQ;
                end
            end
            S_DQ:
            begin
                cmd.op     = scff_pkg::OP_DIVQ;
                state_next = S_WQ;
            end
            S_WQ:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = scff_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/scff_chk.sv -----
// Port-level checker for the feature flow block, bound to the top level.
module scff_chk
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [scff_pkg::DISP_W-1:0] flow_x,
    input logic signed [scff_pkg::DISP_W-1:0] flow_y,
    input logic [scff_pkg::QUAL_W-1:0]        quality,
    input logic [scff_pkg::MAX_FEATURES-1:0]  next_active_mask
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(flow_x) && $stable(flow_y)
                                    && $stable(quality) && $stable(next_active_mask))
        else $error("result changed while stalled");

    // a new result never follows an input transaction directly
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result right after an input transaction");

    // no kept slot means quality zero
    a_qual_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_active_mask == '0 |-> quality == '0)
        else $error("nonzero quality with empty mask");

    // saturated flow never shows the most negative code
    a_flow_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flow_x != 19'sh40000 && flow_y != 19'sh40000)
        else $error("flow outside range");

endmodule

bind sigma_clipped_feature_flow_top scff_chk u_scff_chk
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .flow_x           (flow_x),
    .flow_y           (flow_y),
    .quality          (quality),
    .next_active_mask (next_active_mask)
);
